@@ design/mdo_pkg.sv @@
// shared types and constants of the momentum disturbance observer
package mdo_pkg;

    localparam int JOINTS  = 6;
    localparam int DATA_W  = 32;
    localparam int BETA_W  = DATA_W + 16;
    localparam int JOINT_W = 3;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    // opcodes of the request channel
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_STEP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FREEZE = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] STEP_RESET = 32'd4294967;
    localparam logic [CFG_W-1:0] GAIN_RESET = 32'd4117815;

    // request class decided by the front end
    typedef enum logic [1:0] {
        CLS_JOINT,
        CLS_NOP,
        CLS_CLEAR
    } cls_t;

    // one queued request
    typedef struct packed {
        cls_t                      cls;
        logic [JOINT_W-1:0]        joint;
        logic signed [DATA_W-1:0]  momentum;
        logic signed [DATA_W-1:0]  coriolis;
        logic signed [DATA_W-1:0]  gravity;
        logic signed [DATA_W-1:0]  applied;
    } req_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [CFG_W-1:0] step_size;
        logic [CFG_W-1:0] gain;
        logic             freeze;
    } cfg_t;

endpackage

@@ design/momentum_disturbance_observer_unit.sv @@
// Per-joint momentum observer: a request passes the queue, stages s1 to s5 and the
// result register. Requests for different joints are taken one per cycle unless the
// result stalls; a second update of the same joint waits until the first leaves the
// arithmetic pipeline. Clear waits for in-flight updates, then zeroes all joints.
// Reset clears every joint's state, loads the default timestep and gain,
// and drops freeze; no clearing pass is needed.
module momentum_disturbance_observer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [mdo_pkg::JOINT_W-1:0]        joint,
    input  logic signed [mdo_pkg::DATA_W-1:0]  momentum,
    input  logic signed [mdo_pkg::DATA_W-1:0]  coriolis_term,
    input  logic signed [mdo_pkg::DATA_W-1:0]  gravity_torque,
    input  logic signed [mdo_pkg::DATA_W-1:0]  drive_torque,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mdo_pkg::JOINT_W-1:0]        joint_out,
    output logic signed [mdo_pkg::DATA_W-1:0]  residual,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mdo_pkg::IDX_W-1:0]          cfg_index,
    input  logic [mdo_pkg::CFG_W-1:0]          cfg_data
);

    logic [mdo_pkg::CFG_W-1:0]  step_reg;
    logic [mdo_pkg::CFG_W-1:0]  gain_reg;
    logic                       freeze_reg;
    mdo_pkg::cfg_t              cfg;
    mdo_pkg::req_t              head;
    logic                       head_valid;
    logic                       head_pop;
    logic                       clear_pulse;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= mdo_pkg::STEP_RESET;
            gain_reg   <= mdo_pkg::GAIN_RESET;
            freeze_reg <= 1'b0;
        end
        else if (clear_pulse)
        begin
            freeze_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mdo_pkg::REG_STEP:   step_reg   <= cfg_data;
                mdo_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                mdo_pkg::REG_FREEZE: freeze_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign cfg.step_size = step_reg;
    assign cfg.gain      = gain_reg;
    assign cfg.freeze    = freeze_reg;

    // request intake and queue
    mdo_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .joint          (joint),
        .momentum       (momentum),
        .coriolis_term  (coriolis_term),
        .gravity_torque (gravity_torque),
        .drive_torque   (drive_torque),
        .head           (head),
        .head_valid     (head_valid),
        .head_pop       (head_pop)
    );

    // observer state and arithmetic
    mdo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .cfg         (cfg),
        .clear_pulse (clear_pulse),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .joint_out   (joint_out),
        .residual    (residual)
    );

endmodule

@@ design/mdo_front.sv @@
// front end: accepts requests, classifies them and queues them for the back end
module mdo_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [mdo_pkg::JOINT_W-1:0]       joint,
    input  logic signed [mdo_pkg::DATA_W-1:0] momentum,
    input  logic signed [mdo_pkg::DATA_W-1:0] coriolis_term,
    input  logic signed [mdo_pkg::DATA_W-1:0] gravity_torque,
    input  logic signed [mdo_pkg::DATA_W-1:0] drive_torque,
    output mdo_pkg::req_t                     head,
    output logic                              head_valid,
    input  logic                              head_pop
);

    mdo_pkg::req_t  entry_reg [2];
    mdo_pkg::req_t  req_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;

    // classify the incoming request
    always_comb
    begin
        req_next.joint    = joint;
        req_next.momentum = momentum;
        req_next.coriolis = coriolis_term;
        req_next.gravity  = gravity_torque;
        req_next.applied  = drive_torque;
        unique case (opcode)
            mdo_pkg::OP_CLEAR:
            begin
                req_next.cls = mdo_pkg::CLS_CLEAR;
            end
            default:
            begin
                if (joint < mdo_pkg::JOINT_W'(mdo_pkg::JOINTS))
                    req_next.cls = mdo_pkg::CLS_JOINT;
                else
                    req_next.cls = mdo_pkg::CLS_NOP;
            end
        endcase
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // occupancy of the two-entry queue
    always_comb
    begin
        count_next = count_reg;
        if (push && !head_pop)
            count_next = count_reg + 2'd1;
        else if (!push && head_pop)
            count_next = count_reg - 2'd1;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (head_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= req_next;
    end

endmodule

@@ design/mdo_back.sv @@
// back end: per-joint state, observer arithmetic pipeline and result register
module mdo_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mdo_pkg::req_t                      head,
    input  logic                               head_valid,
    output logic                               head_pop,
    input  mdo_pkg::cfg_t                      cfg,
    output logic                               clear_pulse,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mdo_pkg::JOINT_W-1:0]        joint_out,
    output logic signed [mdo_pkg::DATA_W-1:0]  residual
);

    localparam int DW   = mdo_pkg::DATA_W;
    localparam int BW   = mdo_pkg::BETA_W;
    localparam int JW   = mdo_pkg::JOINT_W;
    localparam int SW   = DW + 2;
    localparam int PW   = SW + mdo_pkg::CFG_W + 1;
    localparam int DLW  = PW - 32;
    localparam int GW   = BW + 17;
    localparam int FW   = GW + 17;
    localparam int RQW  = FW - 16;

    // per-joint state
    logic signed [BW-1:0]   integ_reg [mdo_pkg::JOINTS];
    logic signed [DW-1:0]   resid_reg [mdo_pkg::JOINTS];
    logic signed [DW-1:0]   cor_reg   [mdo_pkg::JOINTS];
    logic signed [DW-1:0]   grav_reg  [mdo_pkg::JOINTS];
    logic [mdo_pkg::JOINTS-1:0] seeded_reg;

    // pipeline control
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic s1_upd_reg, s2_upd_reg, s3_upd_reg, s4_upd_reg, s5_upd_reg;

    // pipeline payload
    logic [JW-1:0]          s1_joint_reg, s2_joint_reg, s3_joint_reg, s4_joint_reg, s5_joint_reg;
    logic signed [DW-1:0]   s1_res_reg, s2_res_reg, s3_res_reg, s4_res_reg, s5_res_reg;
    logic signed [DW-1:0]   s1_p_reg, s2_p_reg, s3_p_reg;
    logic signed [SW-1:0]   s1_sum_reg;
    logic signed [BW-1:0]   s1_beta_reg, s2_beta_reg, s3_beta_reg;
    logic signed [PW-1:0]   s2_prod_reg;
    logic signed [BW-1:0]   s4_diff_reg;
    logic signed [GW-1:0]   s5_ph_reg, s5_pl_reg;

    // result register
    logic                   out_valid_reg;
    logic [JW-1:0]          joint_out_reg;
    logic signed [DW-1:0]   residual_reg;

    logic                   advance;
    logic                   issue;
    logic                   hit;
    logic                   any_upd;
    logic                   block;
    logic [JW-1:0]          jidx;
    logic                   is_joint;
    logic                   is_clear;
    logic                   seed;
    logic                   upd;
    logic signed [DW-1:0]   res_next;
    logic signed [SW-1:0]   sum_next;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   rnd;
    logic signed [DLW-1:0]  delta;
    logic signed [BW+1:0]   beta_sum;
    logic signed [BW-1:0]   beta_next;
    logic signed [BW:0]     diff_wide;
    logic signed [BW-1:0]   diff_next;
    logic signed [GW-1:0]   ph_next;
    logic signed [GW-1:0]   pl_next;
    logic signed [FW-1:0]   full;
    logic signed [RQW-1:0]  rq;
    logic signed [DW-1:0]   r_sat;

    assign advance = !out_valid_reg || out_ready;

    // joints with an update still in flight
    always_comb
    begin
        hit = 1'b0;
        if (s1_v_reg && s1_upd_reg && s1_joint_reg == head.joint) hit = 1'b1;
        if (s2_v_reg && s2_upd_reg && s2_joint_reg == head.joint) hit = 1'b1;
        if (s3_v_reg && s3_upd_reg && s3_joint_reg == head.joint) hit = 1'b1;
        if (s4_v_reg && s4_upd_reg && s4_joint_reg == head.joint) hit = 1'b1;
        if (s5_v_reg && s5_upd_reg && s5_joint_reg == head.joint) hit = 1'b1;
        any_upd = (s1_v_reg && s1_upd_reg) || (s2_v_reg && s2_upd_reg)
                || (s3_v_reg && s3_upd_reg) || (s4_v_reg && s4_upd_reg)
                || (s5_v_reg && s5_upd_reg);
    end

    // issue decision and request decode
    always_comb
    begin
        is_joint = (head.cls == mdo_pkg::CLS_JOINT);
        is_clear = (head.cls == mdo_pkg::CLS_CLEAR);
        block    = (is_joint && hit) || (is_clear && any_upd);
        issue    = head_valid && advance && !block;
        jidx     = head.joint;
        seed     = is_joint && !seeded_reg[jidx];
        upd      = is_joint && seeded_reg[jidx] && !cfg.freeze;
        if (is_joint && seeded_reg[jidx] && cfg.freeze)
            res_next = resid_reg[jidx];
        else
            res_next = '0;
        sum_next = $signed({{2{head.applied[DW-1]}}, head.applied})
                 + $signed({{2{cor_reg[jidx][DW-1]}}, cor_reg[jidx]})
                 + $signed({{2{resid_reg[jidx][DW-1]}}, resid_reg[jidx]})
                 - $signed({{2{grav_reg[jidx][DW-1]}}, grav_reg[jidx]});
    end

    assign head_pop    = issue;
    assign clear_pulse = issue && is_clear;

    // timestep product
    assign prod_next = s1_sum_reg * $signed({1'b0, cfg.step_size});

    // round the increment and add it to the integrator with saturation
    always_comb
    begin
        rnd      = s2_prod_reg + $signed({{(PW-32){1'b0}}, 32'h8000_0000});
        delta    = rnd[PW-1:32];
        beta_sum = $signed({{2{s2_beta_reg[BW-1]}}, s2_beta_reg})
                 + $signed({{(BW+2-DLW){delta[DLW-1]}}, delta});
        if ((&beta_sum[BW+1:BW-1]) || !(|beta_sum[BW+1:BW-1]))
            beta_next = beta_sum[BW-1:0];
        else if (beta_sum[BW+1])
            beta_next = {1'b1, {(BW-1){1'b0}}};
        else
            beta_next = {1'b0, {(BW-1){1'b1}}};
    end

    // momentum error, clamped to the integrator width
    always_comb
    begin
        diff_wide = $signed({{(BW+1-DW){s3_p_reg[DW-1]}}, s3_p_reg})
                  - $signed({s3_beta_reg[BW-1], s3_beta_reg});
        if (diff_wide[BW] == diff_wide[BW-1])
            diff_next = diff_wide[BW-1:0];
        else if (diff_wide[BW])
            diff_next = {1'b1, {(BW-1){1'b0}}};
        else
            diff_next = {1'b0, {(BW-1){1'b1}}};
    end

    // gain product split into two halves of the gain
    assign ph_next = s4_diff_reg * $signed({1'b0, cfg.gain[31:16]});
    assign pl_next = s4_diff_reg * $signed({1'b0, cfg.gain[15:0]});

    // recombine, round and saturate the residual
    always_comb
    begin
        full = $signed({s5_ph_reg[GW-1], s5_ph_reg, 16'h0000})
             + $signed({{17{s5_pl_reg[GW-1]}}, s5_pl_reg})
             + $signed({{(FW-16){1'b0}}, 16'h8000});
        rq   = full[FW-1:16];
        if ((&rq[RQW-1:DW-1]) || !(|rq[RQW-1:DW-1]))
            r_sat = rq[DW-1:0];
        else if (rq[RQW-1])
            r_sat = {1'b1, {(DW-1){1'b0}}};
        else
            r_sat = {1'b0, {(DW-1){1'b1}}};
    end

    // per-joint state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= '0;
            for (int i = 0; i < mdo_pkg::JOINTS; i++)
            begin
                integ_reg[i] <= '0;
                resid_reg[i] <= '0;
                cor_reg[i]   <= '0;
                grav_reg[i]  <= '0;
            end
        end
        else if (issue && is_clear)
        begin
            seeded_reg <= '0;
            for (int i = 0; i < mdo_pkg::JOINTS; i++)
            begin
                integ_reg[i] <= '0;
                resid_reg[i] <= '0;
                cor_reg[i]   <= '0;
                grav_reg[i]  <= '0;
            end
        end
        else
        begin
            if (issue && is_joint)
            begin
                cor_reg[jidx]  <= head.coriolis;
                grav_reg[jidx] <= head.gravity;
                if (seed)
                begin
                    integ_reg[jidx]  <= $signed({{(BW-DW){head.momentum[DW-1]}},
                                                 head.momentum});
                    resid_reg[jidx]  <= '0;
                    seeded_reg[jidx] <= 1'b1;
                end
            end
            if (s3_v_reg && s3_upd_reg)
                integ_reg[s3_joint_reg] <= s3_beta_reg;
            if (s5_v_reg && s5_upd_reg)
                resid_reg[s5_joint_reg] <= r_sat;
        end
    end

    // pipeline and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s1_upd_reg    <= 1'b0;
            s2_upd_reg    <= 1'b0;
            s3_upd_reg    <= 1'b0;
            s4_upd_reg    <= 1'b0;
            s5_upd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            s1_upd_reg    <= issue && upd;
            s2_upd_reg    <= s1_upd_reg;
            s3_upd_reg    <= s2_upd_reg;
            s4_upd_reg    <= s3_upd_reg;
            s5_upd_reg    <= s4_upd_reg;
            out_valid_reg <= s5_v_reg;
        end
    end

    // pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_joint_reg  <= head.joint;
            s1_res_reg    <= res_next;
            s1_p_reg      <= head.momentum;
            s1_sum_reg    <= sum_next;
            s1_beta_reg   <= integ_reg[jidx];

            s2_joint_reg  <= s1_joint_reg;
            s2_res_reg    <= s1_res_reg;
            s2_p_reg      <= s1_p_reg;
            s2_beta_reg   <= s1_beta_reg;
            s2_prod_reg   <= prod_next;

            s3_joint_reg  <= s2_joint_reg;
            s3_res_reg    <= s2_res_reg;
            s3_p_reg      <= s2_p_reg;
            s3_beta_reg   <= beta_next;

            s4_joint_reg  <= s3_joint_reg;
            s4_res_reg    <= s3_res_reg;
            s4_diff_reg   <= diff_next;

            s5_joint_reg  <= s4_joint_reg;
            s5_res_reg    <= s4_res_reg;
            s5_ph_reg     <= ph_next;
            s5_pl_reg     <= pl_next;

            joint_out_reg <= s5_joint_reg;
            residual_reg  <= s5_upd_reg ? r_sat : s5_res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign joint_out = joint_out_reg;
    assign residual  = residual_reg;

    // two updates of the same joint never occupy stages s1 and s2 together
    a_no_joint_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s1_upd_reg && s2_v_reg && s2_upd_reg) |-> (s1_joint_reg != s2_joint_reg))
        else $error("two updates of one joint in flight");

    // a clear request only issues when no update is pending
    a_clear_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && is_clear) |-> !any_upd)
        else $error("clear issued with an update in flight");

    // a clear leaves every joint unseeded
    a_clear_unseeds: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && is_clear) |=> (seeded_reg == '0))
        else $error("joint still seeded after clear");

    // a stalled result is not overwritten
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(residual_reg)))
        else $error("result changed while stalled");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the momentum disturbance observer unit
module tb_top;

    // index with no register behind it
    localparam logic [mdo_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    // arithmetic limits of the observer
    localparam longint BETA_MAX  = 64'sd140737488355327;
    localparam longint BETA_MIN  = -BETA_MAX - 64'sd1;
    localparam longint RES_MAX   = 64'sd2147483647;
    localparam longint RES_MIN   = -RES_MAX - 64'sd1;
    localparam longint SUM_LIM   = 64'sd1099511627776;
    localparam longint GAIN_LIM  = 64'sd1125899906842624;
    localparam longint DT_ROUND  = 64'sd2147483648;
    localparam longint GAIN_ROUND = 64'sd32768;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_PAD      = 10;
    localparam int PHASE_ITEMS    = 220;

    typedef struct packed {
        logic                              op;
        logic [mdo_pkg::JOINT_W-1:0]       joint;
        logic signed [mdo_pkg::DATA_W-1:0] momentum;
        logic signed [mdo_pkg::DATA_W-1:0] coriolis;
        logic signed [mdo_pkg::DATA_W-1:0] gravity;
        logic signed [mdo_pkg::DATA_W-1:0] applied;
    } obs_req_t;

    typedef struct packed {
        logic [mdo_pkg::JOINT_W-1:0]       joint;
        logic signed [mdo_pkg::DATA_W-1:0] residual;
    } obs_res_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic                              opcode;
    logic [mdo_pkg::JOINT_W-1:0]       joint;
    logic signed [mdo_pkg::DATA_W-1:0] momentum;
    logic signed [mdo_pkg::DATA_W-1:0] coriolis_term;
    logic signed [mdo_pkg::DATA_W-1:0] gravity_torque;
    logic signed [mdo_pkg::DATA_W-1:0] drive_torque;
    logic                              out_valid;
    logic                              out_ready;
    logic [mdo_pkg::JOINT_W-1:0]       joint_out;
    logic signed [mdo_pkg::DATA_W-1:0] residual;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [mdo_pkg::IDX_W-1:0]         cfg_index;
    logic [mdo_pkg::CFG_W-1:0]         cfg_data;

    // observer state as the testbench sees it
    logic signed [mdo_pkg::BETA_W-1:0] beta_q   [mdo_pkg::JOINTS];
    logic signed [mdo_pkg::DATA_W-1:0] resid_q  [mdo_pkg::JOINTS];
    logic signed [mdo_pkg::DATA_W-1:0] cor_q    [mdo_pkg::JOINTS];
    logic signed [mdo_pkg::DATA_W-1:0] grav_q   [mdo_pkg::JOINTS];
    bit                                seeded_q [mdo_pkg::JOINTS];
    logic [mdo_pkg::CFG_W-1:0]         step_reg;
    logic [mdo_pkg::CFG_W-1:0]         gain_reg;
    logic                              frozen;

    obs_res_t awaited_residuals[$];
    int       errors;
    bit       idle_on;
    int       tx_gap;
    int       hold_len;

    momentum_disturbance_observer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .joint          (joint),
        .momentum       (momentum),
        .coriolis_term  (coriolis_term),
        .gravity_torque (gravity_torque),
        .drive_torque   (drive_torque),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .joint_out      (joint_out),
        .residual       (residual),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // zero every joint
    function automatic void wipe_state();
        for (int j = 0; j < mdo_pkg::JOINTS; j++)
        begin
            beta_q[j]   = '0;
            resid_q[j]  = '0;
            cor_q[j]    = '0;
            grav_q[j]   = '0;
            seeded_q[j] = 1'b0;
        end
    endfunction

    // apply one request to the local state and return the residual it yields
    function automatic obs_res_t estimate_residual(input obs_req_t r);
        obs_res_t e;
        int       j;
        longint   p, u, c_prev, g_prev, r_prev, sum;
        longint   s_hi, s_lo, g_hi, g_lo, a, b, delta, beta, diff, ga, gb, rr;
        e.joint    = r.joint;
        e.residual = '0;
        if (r.op == mdo_pkg::OP_CLEAR)
        begin
            wipe_state();
            frozen = 1'b0;
        end
        else if (r.joint < mdo_pkg::JOINTS)
        begin
            j = r.joint;
            if (!seeded_q[j])
            begin
                // first update only seeds the integrator
                beta_q[j]   = mdo_pkg::BETA_W'(longint'(r.momentum));
                resid_q[j]  = '0;
                seeded_q[j] = 1'b1;
            end
            else if (!frozen)
            begin
                p      = $signed(r.momentum);
                u      = $signed(r.applied);
                c_prev = $signed(cor_q[j]);
                g_prev = $signed(grav_q[j]);
                r_prev = $signed(resid_q[j]);
                sum    = clip(u + c_prev - g_prev + r_prev, -SUM_LIM, SUM_LIM);
                // integrate with dt split in halves, rounded half up
                s_hi   = longint'(step_reg[31:16]);
                s_lo   = longint'(step_reg[15:0]);
                a      = sum * s_hi;
                b      = sum * s_lo + DT_ROUND;
                delta  = (a + (b >>> 16)) >>> 16;
                beta   = $signed(beta_q[j]);
                beta   = clip(beta + delta, BETA_MIN, BETA_MAX);
                beta_q[j] = mdo_pkg::BETA_W'(beta);
                // residual from the momentum error
                diff   = clip(p - beta, BETA_MIN, BETA_MAX);
                g_hi   = longint'(gain_reg[31:16]);
                g_lo   = longint'(gain_reg[15:0]);
                ga     = clip(diff * g_hi, -GAIN_LIM, GAIN_LIM);
                gb     = diff * g_lo + GAIN_ROUND;
                rr     = ga + (gb >>> 16);
                resid_q[j] = mdo_pkg::DATA_W'(clip(rr, RES_MIN, RES_MAX));
            end
            // model terms are kept even while frozen
            cor_q[j]   = r.coriolis;
            grav_q[j]  = r.gravity;
            e.residual = resid_q[j];
        end
        return e;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // data word: mostly small torques, some full range, some extremes
    function automatic logic signed [mdo_pkg::DATA_W-1:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return {{25{w[6]}}, w[6:0]};
            3, 4, 5: return w;
            default: return {{11{w[20]}}, w[20:0]};
        endcase
    endfunction

    function automatic logic [mdo_pkg::CFG_W-1:0] pick_cfg(input logic [mdo_pkg::CFG_W-1:0] dflt);
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(0, 32'h00FF_FFFF);
            4:       return dflt ^ ($urandom & 32'h0000_FFFF);
            default: return dflt;
        endcase
    endfunction

    function automatic obs_req_t rand_request();
        obs_req_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            r.op    = mdo_pkg::OP_CLEAR;
            r.joint = 3'($urandom_range(0, 7));
        end
        else if (roll < 6)
        begin
            r.op    = mdo_pkg::OP_UPDATE;
            r.joint = 3'($urandom_range(mdo_pkg::JOINTS, 7));
        end
        else
        begin
            r.op    = mdo_pkg::OP_UPDATE;
            r.joint = 3'($urandom_range(0, mdo_pkg::JOINTS - 1));
        end
        r.momentum = pick_word();
        r.coriolis = pick_word();
        r.gravity  = pick_word();
        r.applied  = pick_word();
        return r;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        $display("tb_top mismatch at %0t: %s", $time, msg);
    endtask

    // offer one request, hold it until taken, then record its residual
    task automatic send_request(input obs_req_t r);
        repeat (tx_gap) @(posedge clk);
        in_valid       <= 1'b1;
        opcode         <= r.op;
        joint          <= r.joint;
        momentum       <= r.momentum;
        coriolis_term  <= r.coriolis;
        gravity_torque <= r.gravity;
        drive_torque   <= r.applied;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_residuals.push_back(estimate_residual(r));
        tx_gap = pick_gap();
        if (tx_gap > 0)
            in_valid <= 1'b0;
    endtask

    task automatic send_update(input logic [mdo_pkg::JOINT_W-1:0] j,
                               input logic signed [mdo_pkg::DATA_W-1:0] p,
                               input logic signed [mdo_pkg::DATA_W-1:0] c,
                               input logic signed [mdo_pkg::DATA_W-1:0] g,
                               input logic signed [mdo_pkg::DATA_W-1:0] u);
        obs_req_t r;
        r = '{op: mdo_pkg::OP_UPDATE, joint: j, momentum: p, coriolis: c, gravity: g,
              applied: u};
        send_request(r);
    endtask

    task automatic send_clear(input logic [mdo_pkg::JOINT_W-1:0] j);
        obs_req_t r;
        r = '{op: mdo_pkg::OP_CLEAR, joint: j, momentum: pick_word(), coriolis: pick_word(),
              gravity: pick_word(), applied: pick_word()};
        send_request(r);
    endtask

    // stop offering and wait until every residual has come back
    task automatic settle();
        if (tx_gap == 0)
            in_valid <= 1'b0;
        tx_gap = 0;
        while (awaited_residuals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // one register write; the last of a burst drops valid
    task automatic write_reg(input logic [mdo_pkg::IDX_W-1:0] idx,
                             input logic [mdo_pkg::CFG_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mdo_pkg::REG_STEP:   step_reg = data;
            mdo_pkg::REG_GAIN:   gain_reg = data;
            mdo_pkg::REG_FREEZE: frozen   = data[0];
            default:             ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic program_observer(input logic [mdo_pkg::CFG_W-1:0] dt,
                                    input logic [mdo_pkg::CFG_W-1:0] gain,
                                    input logic frz);
        write_reg(mdo_pkg::REG_STEP, dt, 1'b0);
        write_reg(mdo_pkg::REG_GAIN, gain, 1'b0);
        write_reg(mdo_pkg::REG_FREEZE, {{(mdo_pkg::CFG_W-1){1'b0}}, frz}, 1'b1);
    endtask

    // reset timestep and gain, seeding and saturation of the residual
    task automatic test_default_config();
        idle_on = 1'b0;
        send_update(3'd0, 32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 32'sh0000_4000);
        send_update(3'd0, 32'sh0003_0000, 32'sh0000_1000, 32'shFFFF_0000, 32'sh0001_8000);
        send_update(3'd0, 32'sh0002_8000, 32'sh0000_0000, 32'sh0000_0000, 32'shFFFF_C000);
        send_update(3'd1, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);
        send_update(3'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_update(3'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    // joints out of range, clear, all-zero and all-one words
    task automatic test_field_extremes();
        idle_on = 1'b1;
        send_update(3'd6, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_update(3'd7, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_clear(3'd3);
        send_update(3'd0, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_update(3'd0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_update(3'd5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_update(3'd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_update(3'd5, 32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001);
        send_clear(3'd7);
        send_update(3'd7, 32'sh1234_5678, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    endtask

    // freeze before and after seeding, clear drops freeze, unused index
    task automatic test_freeze_hold();
        settle();
        write_reg(mdo_pkg::REG_FREEZE, 32'd1, 1'b1);
        send_update(3'd2, 32'sh0004_0000, 32'sh0000_2000, 32'sh0001_0000, 32'sh0000_0000);
        send_update(3'd2, 32'sh0009_0000, 32'sh0001_0000, 32'sh0000_0000, 32'sh0002_0000);
        settle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF, 1'b0);
        write_reg(mdo_pkg::REG_FREEZE, 32'hFFFF_FFFE, 1'b1);
        send_update(3'd2, 32'sh0006_0000, 32'sh0000_4000, 32'sh0000_8000, 32'sh0001_0000);
        settle();
        write_reg(mdo_pkg::REG_FREEZE, 32'd1, 1'b1);
        send_update(3'd2, 32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_update(3'd4, 32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_clear(3'd0);
        send_update(3'd2, 32'sh0002_0000, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000);
        send_update(3'd2, 32'sh0005_0000, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000);
        settle();
    endtask

    // corner settings of timestep and gain
    task automatic test_config_extremes();
        logic [mdo_pkg::CFG_W-1:0] dts   [6];
        logic [mdo_pkg::CFG_W-1:0] gains [6];
        dts   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                  mdo_pkg::STEP_RESET};
        gains = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  mdo_pkg::GAIN_RESET};
        idle_on = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            settle();
            program_observer(dts[k], gains[k], 1'b0);
            repeat (25) send_request(rand_request());
        end
    endtask

    // receiver holds off long enough for the unit to fill and stall its input
    task automatic test_output_backpressure();
        settle();
        idle_on  = 1'b0;
        hold_len = 300;
        repeat (60) send_request(rand_request());
        settle();
    endtask

    // random traffic over random settings, one phase without idling
    task automatic test_random_traffic();
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            program_observer(pick_cfg(mdo_pkg::STEP_RESET), pick_cfg(mdo_pkg::GAIN_RESET),
                             $urandom_range(0, 4) == 0);
            idle_on = (ph != 2);
            repeat (PHASE_ITEMS) send_request(rand_request());
        end
    endtask

    // receiver: random stalls plus the requested long hold
    initial
    begin : receiver
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall    = hold_len;
            hold_len = 0;
            if (stall == 0 && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each result with the oldest awaited residual
    always @(posedge clk)
    begin : check_results
        obs_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_residuals.size() == 0)
                report_error($sformatf("result for joint %0d with none pending", joint_out));
            else
            begin
                want = awaited_residuals.pop_front();
                if (joint_out !== want.joint)
                    report_error($sformatf("joint_out got %0d expected %0d",
                                           joint_out, want.joint));
                if (residual !== want.residual)
                    report_error($sformatf("joint %0d residual got %0d expected %0d",
                                           want.joint, residual, want.residual));
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // main sequence
    initial
    begin
        errors         = 0;
        idle_on        = 1'b0;
        tx_gap         = 0;
        hold_len       = 0;
        in_valid       = 1'b0;
        opcode         = mdo_pkg::OP_UPDATE;
        joint          = '0;
        momentum       = '0;
        coriolis_term  = '0;
        gravity_torque = '0;
        drive_torque   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = mdo_pkg::REG_STEP;
        cfg_data       = '0;
        wipe_state();
        step_reg = mdo_pkg::STEP_RESET;
        gain_reg = mdo_pkg::GAIN_RESET;
        frozen   = 1'b0;
        rst_n    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_field_extremes();
        test_freeze_hold();
        test_config_extremes();
        test_output_backpressure();
        test_random_traffic();
        settle();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
